>>> src/mf3_pkg.sv
package mf3_pkg;
   localparam int MaxLineDefault = 1024;
   localparam int PixelBitsDefault = 16;
   localparam int LenWidth = 11;
   localparam int CntWidth = 13;
   localparam int RowWidth = 14;
   localparam logic [LenWidth-1:0] LenReset = 11'd640;
   localparam logic [CntWidth-1:0] CntReset = 13'd480;
   localparam logic CsrLineLength = 1'b0;
   localparam logic CsrLineCount = 1'b1;

   typedef struct packed {
      logic       left_ok;
      logic       right_ok;
      logic       top_ok;
      logic       bot_ok;
      logic       last;
   } win_ctl_type;

   function automatic logic [16:0] sort_key(input logic [15:0] v, input logic ok);
      return ok ? {1'b0, v} : 17'h1FFFF;
   endfunction
endpackage

>>> src/mf3_median.sv
module mf3_median (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [8:0][15:0]           in_vals,
   input  logic [8:0]                 in_ok,
   input  logic                       in_last,
   input  logic                       out_stall,
   output logic                       stall,
   output logic                       out_valid,
   output logic [15:0]                out_median,
   output logic                       out_last
);
   import mf3_pkg::*;

   // Stage 1 registers the keys; stage 2 ranks them, picks the middle pair and averages.
   logic [8:0][16:0] key_ff, key_in;
   logic [3:0]       n_ff, n_in;
   logic             v1_ff, l1_ff;
   logic [8:0][3:0]  rank;
   logic [15:0]      lo_val, hi_val;
   logic [3:0]       lo_idx, hi_idx;
   logic [16:0]      sum;
   logic [15:0]      med_ff;
   logic             v2_ff, l2_ff;
   logic             adv2, adv1;

   always_comb begin
      n_in = '0;
      for (int i = 0; i < 9; i++) begin
         key_in[i] = sort_key(in_vals[i], in_ok[i]);
         n_in = n_in + {3'd0, in_ok[i]};
      end
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         rank[i] = '0;
         for (int j = 0; j < 9; j++) begin
            if ((key_ff[j] < key_ff[i]) || ((key_ff[j] == key_ff[i]) && (j < i))) begin
               rank[i] = rank[i] + 4'd1;
            end
         end
      end
      hi_idx = n_ff >> 1;
      lo_idx = n_ff[0] ? hi_idx : hi_idx - 4'd1;
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < 9; i++) begin
         if (rank[i] == lo_idx) lo_val = key_ff[i][15:0];
         if (rank[i] == hi_idx) hi_val = key_ff[i][15:0];
      end
      sum = {1'b0, lo_val} + {1'b0, hi_val};
   end

   assign adv2 = !v2_ff || !out_stall;
   assign adv1 = !v1_ff || adv2;
   assign stall = !adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
      end
      if (adv1) begin
         key_ff <= key_in;
         n_ff <= n_in;
         l1_ff <= in_last;
      end
      if (adv2) begin
         med_ff <= sum[16:1];
         l2_ff <= l1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_median = med_ff;
   assign out_last = l2_ff;

`ifndef NO_ASSERTIONS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_stall |=> out_valid && $stable(out_median))
      else $error("result changed under stall");
   a_pass: assert property (@(posedge clock) disable iff (reset)
      v1_ff && !stall |=> out_valid)
      else $error("stage one result lost");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> n_ff != 4'd0)
      else $error("empty window");
`endif
endmodule

>>> src/median_filter_3x3.sv
// 3x3 median filter for a raster stream of grey pixels. Program line_length
// and line_count while no transaction is in flight; a register write restarts
// the frame. One pixel or drain transaction is accepted per clock whenever
// req_stall is low, and req_stall rises only when both result stages hold a
// transaction behind rsp_stall. The result for a pixel is produced by the
// transaction that arrives line_length+1 positions later and leaves on rsp
// through a key register, then a rank and select register; the line stores,
// with one read and one write per cycle, are read ahead and add no latency.
// After the last pixel of a frame, send line_length+1 drain transactions to
// flush the remaining results; rsp_frame_last marks the final one. Only
// neighbors inside the image are used, and an even count averages the two
// middle values.
module median_filter_3x3 #(
   parameter int MAX_LINE = mf3_pkg::MaxLineDefault,
   parameter int PIXEL_BITS = mf3_pkg::PixelBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_pixel_value,
   input  logic        req_drain,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_median_value,
   output logic        rsp_frame_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import mf3_pkg::*;
   localparam int AW = $clog2(MAX_LINE);

   logic [LenWidth-1:0] len_ff;
   logic [CntWidth-1:0] cnt_ff;
   logic [RowWidth-1:0] row_ff, row_in, r_use, crow;
   logic [LenWidth-1:0] col_ff, col_in, c_use;
   logic [LenWidth:0]   pend_ff, pend_in;
   logic [LenWidth-1:0] elen;
   logic [RowWidth-1:0] ecnt;
   logic [15:0] upper_mem [MAX_LINE];
   logic [15:0] middle_mem [MAX_LINE];
   logic [15:0] up_q, mid_q;
   logic [AW-1:0] rd_addr;
   logic [15:0] w_ff [6];
   logic [15:0] pix;
   logic acc, act, restart, due, lastflag, is_drain;
   logic [8:0][15:0] vals;
   logic [8:0] ok;
   logic [15:0] colv0, colv1;
   logic med_stall;
   logic sat;
   logic [LenWidth-1:0] ncol;
   logic [AW-1:0] wr_addr;
   logic [LenWidth-1:0] rd_col;
   logic fwd_ff;
   logic [15:0] fup_ff, fmid_ff;
   logic [15:0] mid_fwd, up_fwd;
   logic stale_ff;
   logic [15:0] upper_mem_c0, middle_mem_c0;
   logic [RowWidth+LenWidth:0] pos;

   assign elen = (len_ff == '0) ? LenWidth'(1) :
                 ({21'd0, len_ff} > MAX_LINE) ? LenWidth'(MAX_LINE) : len_ff;
   assign ecnt = (cnt_ff == '0) ? RowWidth'(1) : {1'b0, cnt_ff};
   assign csr_ready = 1'b1;
   assign req_stall = med_stall;
   assign acc = req_valid && !req_stall;
   assign sat = row_ff >= ecnt;
   assign is_drain = req_drain;
   assign act = acc && (is_drain ? (sat && pend_ff != '0) : 1'b1);
   assign restart = !is_drain && sat;
   assign r_use = restart ? '0 : row_ff;
   assign c_use = restart ? '0 : col_ff;
   assign pix = is_drain ? 16'd0 :
                (req_pixel_value & 16'((17'd1 << PIXEL_BITS) - 17'd1));

   // Read address: store is read ahead at the next column.
   assign ncol = (c_use + 1'b1 >= elen) ? '0 : c_use + 1'b1;
   assign wr_addr = c_use[AW-1:0];

   assign rd_col = act ? ncol : col_ff;
   assign rd_addr = rd_col[AW-1:0];

   always_ff @(posedge clock) begin
      if (act) begin
         upper_mem[wr_addr] <= mid_fwd;
         middle_mem[wr_addr] <= pix;
      end
      up_q <= upper_mem[rd_addr];
      mid_q <= middle_mem[rd_addr];
   end

   // Forwarding: reading the entry being written in the same cycle (len 1).
   always_ff @(posedge clock) begin
      fwd_ff <= act && (rd_addr == wr_addr);
      fup_ff <= mid_fwd;
      fmid_ff <= pix;
   end
   assign up_fwd = fwd_ff ? fup_ff : up_q;
   assign mid_fwd = fwd_ff ? fmid_ff : mid_q;
   // Read data corresponds to col_ff except on a restart or after a reset or register write.
   assign colv0 = (restart || stale_ff) ? upper_mem_c0 : up_fwd;
   assign colv1 = (restart || stale_ff) ? middle_mem_c0 : mid_fwd;
   assign upper_mem_c0 = 16'd0;
   assign middle_mem_c0 = 16'd0;

   always_comb begin
      pos = r_use * elen + c_use;
      due = act && (pos >= elen + 1'b1);
      if (c_use >= 1) begin
         crow = r_use - 1'b1;
         ok = '0;
      end else begin
         crow = r_use - 2'd2;
      end
      ok = '0;
      vals = '0;
      for (int k = 0; k < 3; k++) begin
         logic rowok;
         rowok = (k == 0) ? (crow >= 1) : (k == 2) ? (crow + 1'b1 < ecnt) : 1'b1;
         vals[k*3] = w_ff[3+k];
         vals[k*3+1] = w_ff[k];
         vals[k*3+2] = (k == 0) ? colv0 : (k == 1) ? colv1 : pix;
         ok[k*3] = rowok && ((c_use >= 1) ? (c_use >= 2) : (elen >= 2));
         ok[k*3+1] = rowok;
         ok[k*3+2] = rowok && (c_use >= 1);
      end
      lastflag = is_drain && (pend_ff == 1);
      col_in = ncol;
      row_in = (c_use + 1'b1 >= elen) ? r_use + 1'b1 : r_use;
      pend_in = is_drain ? pend_ff - 1'b1 : (restart ? '0 : pend_ff);
      if (is_drain && pend_ff == 1) begin
         col_in = '0;
         row_in = '0;
      end
      if (!is_drain && row_in >= ecnt) pend_in = {1'b0, elen} + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LenReset;
         cnt_ff <= CntReset;
         col_ff <= '0;
         row_ff <= '0;
         pend_ff <= '0;
         stale_ff <= 1'b1;
         for (int i = 0; i < 6; i++) w_ff[i] <= '0;
      end else if (csr_valid) begin
         if (csr_index == CsrLineLength) len_ff <= csr_data[LenWidth-1:0];
         else cnt_ff <= csr_data[CntWidth-1:0];
         col_ff <= '0;
         row_ff <= '0;
         pend_ff <= '0;
         stale_ff <= 1'b1;
      end else begin
         if (act) begin
            col_ff <= col_in;
            row_ff <= row_in;
            pend_ff <= pend_in;
            w_ff[3] <= w_ff[0];
            w_ff[4] <= w_ff[1];
            w_ff[5] <= w_ff[2];
            w_ff[0] <= colv0;
            w_ff[1] <= colv1;
            w_ff[2] <= pix;
            stale_ff <= 1'b0;
         end else if (acc) begin
            stale_ff <= stale_ff;
         end
      end
   end

   mf3_median u_med (
      .clock(clock), .reset(reset), .in_valid(due), .in_vals(vals), .in_ok(ok),
      .in_last(lastflag), .out_stall(rsp_stall), .stall(med_stall),
      .out_valid(rsp_valid), .out_median(rsp_median_value), .out_last(rsp_frame_last)
   );

`ifndef NO_ASSERTIONS
   a_pend: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= {1'b0, elen} + 1'b1) else $error("pending count overflow");
   a_col: assert property (@(posedge clock) disable iff (reset)
      col_ff < elen || col_ff == '0) else $error("column out of range");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      acc && req_drain && !sat |-> !due) else $error("early drain produced result");
`endif
endmodule
